### rtl/tbpr_pkg.sv
// Package for the tile background pixel renderer: constants, codes and shared types.
// No dependencies; imported by tbpr_vram and tile_background_pixel_renderer_core.
package tbpr_pkg;

  // Video memory geometry (fixed)
  localparam int VIDEO_MEM_BYTES = 8192;
  localparam int VM_AW           = $clog2(VIDEO_MEM_BYTES);
  localparam int BANK_AW         = VM_AW - 1;
  localparam int BANK_DEPTH      = VIDEO_MEM_BYTES / 2;

  // Defaults for the top-level parameters
  localparam int DEF_SCREEN_W        = 160;
  localparam int DEF_SCREEN_H        = 144;
  localparam int DEF_LINES_PER_FRAME = 154;

  // Dot counter: -80 .. 375, held as an offset count 0 .. 455
  localparam int DOT_FIRST  = -80;
  localparam int DOT_LIMIT  = 376;
  localparam int DOT_SPAN   = DOT_LIMIT - DOT_FIRST;
  localparam int DOT_OFFSET = -DOT_FIRST;
  localparam int DOT_W      = $clog2(DOT_SPAN);
  localparam int LINE_W     = 8;
  localparam int COORD_W    = 8;

  // Tile map bases and signed tile-data addressing
  localparam logic [VM_AW-1:0] MAP_LOW      = 13'h1800;
  localparam logic [VM_AW-1:0] MAP_HIGH     = 13'h1C00;
  localparam logic [7:0]       SIGNED_SPLIT = 8'h80;
  localparam logic [8:0]       SIGNED_SHIFT = 9'h100;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Input item kind (tuser)
  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  // Configuration register indexes
  localparam logic [7:0] CFG_BG_MAP_SELECT    = 8'd0;
  localparam logic [7:0] CFG_TILE_DATA_SELECT = 8'd1;

  // Write request into video memory
  typedef struct packed {
    logic             en;
    logic [VM_AW-1:0] addr;
    logic [7:0]       data;
  } vram_wr_t;

  // One result item
  typedef struct packed {
    logic               pixel_valid;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [1:0]         pixel_color;
    logic               vblank_irq;
    logic               frame_end;
  } out_item_t;

endpackage

### rtl/tbpr_vram.sv
// Video memory: two byte banks (even / odd addresses), one write and two registered reads each.
// Depends on tbpr_pkg.
module tbpr_vram
  import tbpr_pkg::*;
(
  input  logic                    clk,
  input  vram_wr_t                wr,
  input  logic [BANK_AW-1:0]      map_idx,
  input  logic [BANK_AW-1:0]      plane_idx,
  output logic [1:0][7:0]         map_rd,
  output logic [1:0][7:0]         plane_rd
);

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];
    logic [7:0] map_q;
    logic [7:0] plane_q;

    // read-before-write on a same-edge collision
    always_ff @(posedge clk) begin
      if (wr.en && (wr.addr[0] == 1'(b))) begin
        mem[wr.addr[VM_AW-1:1]] <= wr.data;
      end
      map_q   <= mem[map_idx];
      plane_q <= mem[plane_idx];
    end

    assign map_rd[b]   = map_q;
    assign plane_rd[b] = plane_q;
  end

endmodule

### rtl/tile_background_pixel_renderer_core.sv
// Top level of the tile background pixel renderer: counters, fetch pipeline, output queue.
// Depends on tbpr_pkg and tbpr_vram.
//
// Streams background pixels from 8 KiB of tile video memory. Each input transaction is either
// a dot tick (tuser = 0) or a one-byte video memory write (tuser = 1). Writes give no output;
// every tick gives exactly one output transaction carrying the pixel (tuser high when the dot
// is visible, coordinates and colour otherwise zero) and the vertical-blank flag, with tlast
// marking the tick that enters line SCREEN_H (end of the visible frame). The block takes one
// transaction per clock cycle while s_tready is high. A tick is registered into stage 1 and then
// stage 2 before it is written to the output queue: the tile map byte and then the two bitplane
// bytes are each a registered read of the video memory, which is split into even and odd byte
// banks so both bitplanes of a row come back in one read. A write takes effect at the edge it is
// accepted, so a tick sees exactly the writes accepted before it. A four-entry queue sits in front
// of the master port; s_tready is low during reset and otherwise drops only when the queue plus the
// ticks still being fetched would overfill it. Configuration writes are always taken outside reset
// (cfg_ready is high whenever rst is low) and must be issued while the block is idle.
// Video memory has no reset; reading a byte never written is undefined.
module tile_background_pixel_renderer_core
  import tbpr_pkg::*;
#(
  parameter int SCREEN_W        = DEF_SCREEN_W,
  parameter int SCREEN_H        = DEF_SCREEN_H,
  parameter int LINES_PER_FRAME = DEF_LINES_PER_FRAME
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [12:0] mem_addr, [20:13] mem_data, [23:21] zero
  input  logic        s_tuser,   // [0] action
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [17:16] pixel_color,
                                 // [18] vblank_irq, [23:19] zero
  output logic        m_tuser,   // [0] pixel_valid
  output logic        m_tlast,   // frame_end
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [DOT_W:0]    VIS_FIRST = (DOT_W+1)'(DOT_OFFSET);
  localparam logic [DOT_W:0]    VIS_END   = (DOT_W+1)'(DOT_OFFSET + SCREEN_W);
  localparam logic [DOT_W-1:0]  DOT_LAST  = DOT_W'(DOT_SPAN - 1);
  localparam logic [DOT_W-1:0]  DOT_RST   = DOT_W'(DOT_OFFSET);
  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES_PER_FRAME - 1);
  localparam logic [LINE_W-1:0] LINE_VBL  = LINE_W'(SCREEN_H);

  // ---------------------------------------------------------------- configuration
  logic bg_map_select;
  logic tile_data_select;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_map_select    <= 1'b0;
      tile_data_select <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BG_MAP_SELECT:    bg_map_select    <= cfg_data[0];
        CFG_TILE_DATA_SELECT: tile_data_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input decode
  logic     in_acc;
  logic     tick_acc;
  vram_wr_t vram_wr;

  assign in_acc   = s_tvalid && s_tready;
  assign tick_acc = in_acc && (s_tuser == ACT_TICK);

  always_comb begin
    vram_wr.en   = in_acc && (s_tuser == ACT_WRITE);
    vram_wr.addr = s_tdata[VM_AW-1:0];
    vram_wr.data = s_tdata[VM_AW+7:VM_AW];
  end

  // ---------------------------------------------------------------- dot / line counters
  // dot_pos = dot + 80, so reset value 80 is dot 0
  logic [DOT_W-1:0]  dot_pos, dot_pos_next;
  logic [LINE_W-1:0] line, line_next;
  logic              dot_wrap;
  logic              vblank_now;
  logic              visible;
  logic [COORD_W-1:0] px;
  logic [VM_AW-1:0]  map_addr;

  always_comb begin
    dot_wrap     = (dot_pos == DOT_LAST);
    dot_pos_next = dot_wrap ? '0 : dot_pos + 1'b1;
    if (!dot_wrap)              line_next = line;
    else if (line == LINE_LAST) line_next = '0;
    else                        line_next = line + 1'b1;
    vblank_now = dot_wrap && (line_next == LINE_VBL);
    visible    = (line_next < LINE_VBL) &&
                 ({1'b0, dot_pos_next} >= VIS_FIRST) &&
                 ({1'b0, dot_pos_next} <  VIS_END);
    px         = COORD_W'(dot_pos_next - DOT_RST);
    // 32x32 map: row = y / 8, column = x / 8
    map_addr   = (bg_map_select ? MAP_HIGH : MAP_LOW) +
                 {3'b000, line_next[7:3], px[7:3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_pos <= DOT_RST;
      line    <= '0;
    end else if (tick_acc) begin
      dot_pos <= dot_pos_next;
      line    <= line_next;
    end
  end

  // ---------------------------------------------------------------- fetch pipeline
  logic             s1_valid, s2_valid;
  out_item_t        s1_item, s2_item;
  logic             s1_bank;
  logic [1:0][7:0]  map_rd, plane_rd;
  logic [7:0]       tile;
  logic [8:0]       tile_id;
  logic [VM_AW-1:0] row_addr;

  // stage 1: tile id from the map byte, bitplane row address
  always_comb begin
    tile     = map_rd[s1_bank];
    tile_id  = {1'b0, tile} +
               ((!tile_data_select && (tile < SIGNED_SPLIT)) ? SIGNED_SHIFT : 9'd0);
    row_addr = {tile_id, s1_item.pixel_y[2:0], 1'b0};   // tile * 16 + fine y * 2
  end

  tbpr_vram u_vram (
    .clk       (clk),
    .wr        (vram_wr),
    .map_idx   (map_addr[VM_AW-1:1]),
    .plane_idx (row_addr[VM_AW-1:1]),
    .map_rd    (map_rd),
    .plane_rd  (plane_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= tick_acc;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_item.pixel_valid <= visible;
    s1_item.pixel_x     <= visible ? px : '0;
    s1_item.pixel_y     <= visible ? line_next : '0;
    s1_item.pixel_color <= '0;
    s1_item.vblank_irq  <= vblank_now;
    s1_item.frame_end   <= vblank_now;
    s1_bank             <= map_addr[0];
    s2_item             <= s1_item;
  end

  // stage 2: pick the pixel bit (bit 7 is leftmost) from both bitplanes
  out_item_t s2_out;
  logic [2:0] bit_sel;

  always_comb begin
    bit_sel = ~s2_item.pixel_x[2:0];
    s2_out  = s2_item;
    s2_out.pixel_color = s2_item.pixel_valid ?
                         {plane_rd[1][bit_sel], plane_rd[0][bit_sel]} : 2'b00;
  end

  // ---------------------------------------------------------------- output queue
  out_item_t          fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               push, pop;
  logic [FIFO_AW+1:0] in_flight;
  out_item_t          head;

  assign push = s2_valid;
  assign pop  = m_tvalid && m_tready;

  // every tick in flight already owns a queue slot
  assign in_flight = (FIFO_AW+2)'(count) + (FIFO_AW+2)'(s1_valid) + (FIFO_AW+2)'(s2_valid);
  assign s_tready  = !rst && (in_flight < (FIFO_AW+2)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr] <= s2_out;
  end

  assign head     = fifo_mem[rd_ptr];
  assign m_tvalid = (count != '0);
  assign m_tuser  = head.pixel_valid;
  assign m_tlast  = head.frame_end;
  assign m_tdata  = {5'b00000, head.vblank_irq, head.pixel_color, head.pixel_y, head.pixel_x};

endmodule
